// ----- sv/display_p3_to_srgb_matrix_defines.svh -----
// Assertion helpers used by the checker file p3s_checker.sv.
`ifndef DISPLAY_P3_TO_SRGB_MATRIX_DEFINES_SVH
`define DISPLAY_P3_TO_SRGB_MATRIX_DEFINES_SVH

// Clocked check, switched off while reset is held.
`define P3S_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define P3S_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/p3s_pkg.sv -----
package p3s_pkg;

    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int PIX_W              = 8;
    localparam int XYZ_FRAC_BITS      = 8;
    // X, Y, Z stay below 1.09 * 255 with 8 fraction bits
    localparam int XYZ_W              = 17;
    localparam longint DEC_SCALE      = 64'sd100000000;

    typedef logic [2:0][PIX_W-1:0] t_pix;   // [0] red, [1] green, [2] blue
    typedef logic [2:0][XYZ_W-1:0] t_xyz;   // [0] X, [1] Y, [2] Z

    // Matrix entries as decimal value times 1e8, row major
    localparam longint P3_TO_XYZ_DEC [9] = '{
        64'sd48657095, 64'sd26566769, 64'sd19821729,
        64'sd22897457, 64'sd69173852, 64'sd7928691,
        64'sd0,        64'sd4511338,  64'sd104394437
    };

    localparam longint XYZ_TO_SRGB_DEC [9] = '{
        64'sd324060000,  -64'sd153720000, -64'sd49860000,
        -64'sd96890000,  64'sd187580000,  64'sd4150000,
        64'sd5570000,    -64'sd20400000,  64'sd105700000
    };

    // Fixed-point coefficient, rounded to nearest, ties away from zero
    function automatic longint quant_coef(input longint dec, input int frac);
        longint one;
        longint q;
        one = longint'(1) << frac;
        if (dec < 0) begin
            q = -(((-dec) * one + DEC_SCALE / 2) / DEC_SCALE);
        end else begin
            q = (dec * one + DEC_SCALE / 2) / DEC_SCALE;
        end
        return q;
    endfunction

endpackage

// ----- sv/p3s_xyz_stage.sv -----
module p3s_xyz_stage #(
    parameter int COEF_FRAC_BITS = p3s_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  p3s_pkg::t_pix i_pix,
    output logic          o_valid,
    input  logic          i_ready,
    output p3s_pkg::t_xyz o_xyz
);

    localparam int C1_W   = COEF_FRAC_BITS + 1;           // all entries below 2.0
    localparam int P1_W   = p3s_pkg::PIX_W + C1_W;
    localparam int ACC1_W = P1_W + 3;                     // three terms plus round
    localparam int SH1    = COEF_FRAC_BITS - p3s_pkg::XYZ_FRAC_BITS;

    localparam logic [ACC1_W-1:0] HALF1 = ACC1_W'(1) << (SH1 - 1);

    logic [P1_W-1:0] r_prod [9];
    logic            r_v1;
    logic            r_v2;
    logic            n_v1;
    logic            n_v2;
    logic            adv1;
    logic            adv2;
    p3s_pkg::t_xyz   r_xyz;
    p3s_pkg::t_xyz   xyz_rnd;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_xyz   = r_xyz;

    always_comb begin
        n_v1 = adv1 ? i_valid : r_v1;
        n_v2 = adv2 ? r_v1 : r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_mul
        localparam logic [C1_W-1:0] COEF =
            C1_W'(p3s_pkg::quant_coef(p3s_pkg::P3_TO_XYZ_DEC[k], COEF_FRAC_BITS));
        always_ff @(posedge i_clk) begin
            if (adv1) begin
                r_prod[k] <= P1_W'(i_pix[k % 3]) * P1_W'(COEF);
            end
        end
    end

    // all terms non-negative: plain add-half round
    for (genvar r = 0; r < 3; r++) begin : g_row
        logic [ACC1_W-1:0] acc;
        assign acc = ACC1_W'(r_prod[3*r]) + ACC1_W'(r_prod[3*r+1])
                   + ACC1_W'(r_prod[3*r+2]) + HALF1;
        assign xyz_rnd[r] = p3s_pkg::XYZ_W'(acc >> SH1);
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_xyz <= xyz_rnd;
        end
    end

endmodule

// ----- sv/p3s_rgb_stage.sv -----
module p3s_rgb_stage #(
    parameter int COEF_FRAC_BITS = p3s_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  p3s_pkg::t_xyz i_xyz,
    output logic          o_valid,
    input  logic          i_ready,
    output p3s_pkg::t_pix o_pix
);

    localparam int C2_W  = COEF_FRAC_BITS + 3;            // |entry| below 4.0, signed
    localparam int X_W   = p3s_pkg::XYZ_W + 1;
    localparam int P2_W  = X_W + C2_W;
    localparam int ACC_W = P2_W + 3;
    localparam int SH2   = COEF_FRAC_BITS + p3s_pkg::XYZ_FRAC_BITS;
    localparam int HI_W  = ACC_W - SH2;

    localparam logic signed [ACC_W-1:0] HALF2 = ACC_W'(1) <<< (SH2 - 1);

    logic signed [P2_W-1:0] r_prod [9];
    logic                   r_v1;
    logic                   r_v2;
    logic                   n_v1;
    logic                   n_v2;
    logic                   adv1;
    logic                   adv2;
    p3s_pkg::t_pix          r_pix;
    p3s_pkg::t_pix          pix_clip;

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_pix   = r_pix;

    always_comb begin
        n_v1 = adv1 ? i_valid : r_v1;
        n_v2 = adv2 ? r_v1 : r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_mul
        localparam logic signed [C2_W-1:0] COEF =
            C2_W'(p3s_pkg::quant_coef(p3s_pkg::XYZ_TO_SRGB_DEC[k], COEF_FRAC_BITS));
        logic signed [X_W-1:0] x_s;
        assign x_s = $signed({1'b0, i_xyz[k % 3]});
        always_ff @(posedge i_clk) begin
            if (adv1) begin
                r_prod[k] <= P2_W'(x_s) * P2_W'(COEF);
            end
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] rnd;
        logic        [HI_W-1:0]  hi;
        assign acc = ACC_W'(r_prod[3*r]) + ACC_W'(r_prod[3*r+1]) + ACC_W'(r_prod[3*r+2]);
        assign rnd = acc + HALF2;
        assign hi  = rnd[ACC_W-1:SH2];
        always_comb begin
            if (acc <= 0) begin
                pix_clip[r] = '0;
            end else if (|hi[HI_W-1:p3s_pkg::PIX_W]) begin
                pix_clip[r] = '1;
            end else begin
                pix_clip[r] = hi[p3s_pkg::PIX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_pix <= pix_clip;
        end
    end

endmodule

// ----- sv/display_p3_to_srgb_matrix.sv -----
// Display P3 to sRGB color matrix, four register stages.
// Throughput: one item per cycle while m_axis_tready is high;
// each stage advances on its own, so bubbles close up.
// The stages are two multiply ranks and two add/round ranks (XYZ, then sRGB).
// Reset (i_rst_n low, synchronous) clears the valid bits; data registers are not reset.
module display_p3_to_srgb_matrix #(
    parameter int COEF_FRAC_BITS = p3s_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // out_red, out_green, out_blue
);

    logic          xyz_valid;
    logic          xyz_ready;
    p3s_pkg::t_xyz xyz;
    p3s_pkg::t_pix pix_out;

    p3s_xyz_stage #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_xyz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pix   (p3s_pkg::t_pix'(s_axis_tdata)),
        .o_valid (xyz_valid),
        .i_ready (xyz_ready),
        .o_xyz   (xyz)
    );

    p3s_rgb_stage #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_rgb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (xyz_valid),
        .o_ready (xyz_ready),
        .i_xyz   (xyz),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pix   (pix_out)
    );

    assign m_axis_tdata = 24'(pix_out);

endmodule

// ----- sv/p3s_checker.sv -----
`include "display_p3_to_srgb_matrix_defines.svh"

module p3s_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // items in flight between the two ports
    always_comb begin
        n_cnt = r_cnt + 3'(in_acc) - 3'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `P3S_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
    `P3S_ASSERT(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "stalled result changed")
    `P3S_ASSERT(a_no_invent, i_clk, i_rst_n, m_axis_tvalid |-> r_cnt != 3'd0, "result without item")
    `P3S_ASSERT(a_depth, i_clk, i_rst_n, r_cnt <= 3'd4, "more items in flight than stages")

endmodule

bind display_p3_to_srgb_matrix p3s_checker u_p3s_checker (.*);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int     FRAC        = p3s_pkg::COEF_FRAC_BITS_DEF;
    localparam int     XYZ_SHIFT   = FRAC - p3s_pkg::XYZ_FRAC_BITS;
    localparam int     OUT_SHIFT   = FRAC + p3s_pkg::XYZ_FRAC_BITS;
    localparam int     RAND_ITEMS  = 1400;
    localparam int     HOLD_CYCLES = 200;
    localparam longint CYCLE_LIMIT = 200000;

    // Matrix entries scaled by 1e8, row major
    localparam longint PRIM_TO_XYZ [9] = '{
        48657095, 26566769, 19821729,
        22897457, 69173852, 7928691,
        0,        4511338,  104394437
    };
    localparam longint XYZ_TO_OUT [9] = '{
        324060000, -153720000, -49860000,
        -96890000, 187580000,  4150000,
        5570000,   -20400000,  105700000
    };

    typedef struct {
        p3s_pkg::t_pix pix;
        bit            typed;
        p3s_pkg::t_pix want;
    } t_pix_row;

    // Pixels written as 24'hBBGGRR
    t_pix_row dir_rows [20] = '{
        '{24'h000000, 1'b1, 24'h000000},
        '{24'h0000FF, 1'b1, 24'h0000FF},   // P3 red: green and blue go negative
        '{24'h00FF00, 1'b1, 24'h00FF00},   // P3 green: red and blue go negative
        '{24'hFF0000, 1'b0, 24'h000000},
        '{24'hFFFFFF, 1'b0, 24'h000000},
        '{24'h00FFFF, 1'b0, 24'h000000},
        '{24'hFFFF00, 1'b0, 24'h000000},
        '{24'hFF00FF, 1'b0, 24'h000000},
        '{24'h010101, 1'b0, 24'h000000},
        '{24'h7F7F7F, 1'b0, 24'h000000},
        '{24'h808080, 1'b0, 24'h000000},
        '{24'hFEFEFE, 1'b0, 24'h000000},
        '{24'h555555, 1'b0, 24'h000000},
        '{24'hAAAAAA, 1'b0, 24'h000000},
        '{24'h000001, 1'b0, 24'h000000},
        '{24'h000100, 1'b0, 24'h000000},
        '{24'h010000, 1'b0, 24'h000000},
        '{24'h0000FE, 1'b0, 24'h000000},
        '{24'h204080, 1'b0, 24'h000000},
        '{24'h804020, 1'b0, 24'h000000}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // in_red, in_green, in_blue
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // out_red, out_green, out_blue

    p3s_pkg::t_pix srgb_due [$];
    int            mismatches = 0;
    longint        cycle_cnt = 0;
    bit            steady;
    bit            hold_req;
    bit            hold_done = 1'b0;
    int            hold_cnt;

    display_p3_to_srgb_matrix dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic longint coef_q(input longint dec);
        longint mag;
        mag = (dec < 0) ? -dec : dec;
        mag = (mag * (longint'(1) << FRAC) + 50000000) / 100000000;
        return (dec < 0) ? -mag : mag;
    endfunction

    function automatic p3s_pkg::t_pix p3_to_srgb(input p3s_pkg::t_pix p);
        longint        acc;
        longint        xyz [3];
        p3s_pkg::t_pix res;
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) begin
                acc += coef_q(PRIM_TO_XYZ[r*3+c]) * longint'(p[c]);
            end
            xyz[r] = (acc + (longint'(1) << (XYZ_SHIFT - 1))) >>> XYZ_SHIFT;
        end
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) begin
                acc += coef_q(XYZ_TO_OUT[r*3+c]) * xyz[c];
            end
            if (acc <= 0) begin
                res[r] = 8'd0;
            end else begin
                acc = (acc + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
                res[r] = (acc > 255) ? 8'd255 : acc[7:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
        mismatches++;
    endtask

    // Offer one pixel, with random gaps ahead of it, and wait until it is taken
    task automatic send_pixel(input p3s_pkg::t_pix p, input bit typed,
                              input p3s_pkg::t_pix want);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
        srgb_due.push_back(typed ? want : p3_to_srgb(p));
    endtask

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        p3s_pkg::t_pix got;
        p3s_pkg::t_pix want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (srgb_due.size() == 0) begin
                report_mismatch("unexpected item", int'(got), 0);
            end else begin
                want = srgb_due.pop_front();
                for (int ch = 0; ch < 3; ch++) begin
                    if (got[ch] !== want[ch]) begin
                        report_mismatch(ch == 0 ? "red" : ch == 1 ? "green" : "blue",
                                        int'(got[ch]), int'(want[ch]));
                    end
                end
            end
        end
    end

    // Receiver: random backpressure, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    initial begin
        p3s_pkg::t_pix pix;
        int            mode;
        int            base;
        steady        = 1'b0;
        hold_req      = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_pixel(dir_rows[k].pix, dir_rows[k].typed, dir_rows[k].want);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            steady = (n >= 600 && n < 800);
            if (n == 300) hold_req = 1'b1;
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                pix = 24'($urandom());
            end else if (mode < 8) begin
                // channels at the rails or random: drives clipping on both ends
                for (int ch = 0; ch < 3; ch++) begin
                    case ($urandom_range(0, 2))
                        0:       pix[ch] = 8'd0;
                        1:       pix[ch] = 8'd255;
                        default: pix[ch] = 8'($urandom_range(0, 255));
                    endcase
                end
            end else begin
                // near gray: outputs land near input, exercising rounding
                base = $urandom_range(0, 255);
                for (int ch = 0; ch < 3; ch++) begin
                    pix[ch] = 8'(base + $urandom_range(0, 6) - 3);
                end
            end
            send_pixel(pix, 1'b0, '0);
        end
        steady = 1'b0;

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (srgb_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
